>>> src/prct_pkg.sv
// prct_pkg: shared types and constants of the paged row copy address translator
// item kinds, result status codes, register indexes and fixed field widths
// no dependencies
`default_nettype none

package prct_pkg;

   localparam int OFFSET_WIDTH = 54;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 16;

   typedef enum logic [1:0] {
      KIND_WRITE_SOURCE = 2'd0,
      KIND_WRITE_DEST   = 2'd1,
      KIND_COPY         = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BEYOND_COUNT = 3'd1,
      ST_NEGATIVE     = 3'd2,
      ST_COLUMN_RANGE = 3'd3,
      ST_UNMAPPED     = 3'd4
   } status_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PACKED_ROW_BYTES = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COPY_CAPACITY    = 4'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOURCE_BLOCKS    = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEST_BLOCKS      = 4'd3;

endpackage

`default_nettype wire

>>> src/prct_ram.sv
// prct_ram: generic single write port, single read port ram with registered read
// read data holds while rd_en is low; no dependencies
`default_nettype none

module prct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/paged_row_copy_address_translator.sv
// paged_row_copy_address_translator: top level, four stage translation pipeline
// depends on prct_pkg and prct_ram
//
// usage:
//   req_ channel carries table writes (kind 0 source, kind 1 destination) and copy
//   requests (kind 2); kind 3 is dropped. only copy requests give a transfer on
//   the rsp_ channel: a status and two byte offsets, zero unless status is ok.
//   csr_ channel writes the four registers by index and is always ready; write
//   only while the pipeline is empty.
// timing:
//   one item per cycle unless a stage stalls. a copy request goes through the
//   input register, block table read, row build, multiply into the output
//   register. the two block table rams are read and written in item order
//   from the same stage, so a write is seen by any later request.
// stalls:
//   each stage holds its item while the next one is full and blocked; ready
//   falls only when every stage is full, so a waiting result does not stop
//   the items behind it until the pipeline fills.
// reset:
//   clears all stage valid bits and sets registers to defaults; table contents are
//   undefined until written. TOKENS_PER_BLOCK must be a power of two; not enforced.
`default_nettype none

module paged_row_copy_address_translator #(
   parameter int MAX_BATCHES = 16,
   parameter int MAX_BLOCKS_PER_SEQ = 256,
   parameter int TOKENS_PER_BLOCK = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_kind,
   input  logic [3:0]                           req_batch,
   input  logic [7:0]                           req_table_column,
   input  logic signed [31:0]                   req_block_id,
   input  logic [15:0]                          req_copy_index,
   input  logic signed [31:0]                   req_copy_count,
   input  logic signed [31:0]                   req_source_token,
   input  logic signed [31:0]                   req_destination_slot,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_status,
   output logic [prct_pkg::OFFSET_WIDTH-1:0]    rsp_source_byte_offset,
   output logic [prct_pkg::OFFSET_WIDTH-1:0]    rsp_destination_byte_offset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [prct_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [prct_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   import prct_pkg::*;

   localparam int DEPTH = MAX_BATCHES * MAX_BLOCKS_PER_SEQ;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(TOKENS_PER_BLOCK);
   localparam int SCW = 31 - OW;
   localparam int RW = 31 + OW;
   localparam int PW = (RW + 16 > OFFSET_WIDTH) ? RW + 16 : OFFSET_WIDTH;
   localparam logic [31:0] MAX_BATCHES_U = 32'(MAX_BATCHES);
   localparam logic [31:0] MAX_BLOCKS_U = 32'(MAX_BLOCKS_PER_SEQ);

   // configuration registers
   logic [15:0] row_bytes_ff;
   logic [15:0] capacity_ff;
   logic [8:0]  src_limit_ff;
   logic [8:0]  dst_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= 16'd1;
         capacity_ff  <= 16'd0;
         src_limit_ff <= 9'd256;
         dst_limit_ff <= 9'd256;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PACKED_ROW_BYTES: row_bytes_ff <= csr_data;
            CSR_COPY_CAPACITY:    capacity_ff  <= csr_data;
            CSR_SOURCE_BLOCKS:    src_limit_ff <= csr_data[8:0];
            CSR_DEST_BLOCKS:      dst_limit_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s2_ready, s3_ready, out_ready, s1_move;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign req_ready = !s1_valid_ff || s2_ready;
   assign s1_move   = s1_valid_ff && s2_ready;

   // stage 1: input register
   logic [1:0]  s1_kind_ff;
   logic [3:0]  s1_batch_ff;
   logic [7:0]  s1_column_ff;
   logic [31:0] s1_block_ff;
   logic [15:0] s1_index_ff;
   logic [31:0] s1_count_ff;
   logic [31:0] s1_token_ff;
   logic [31:0] s1_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_ready) begin
         s1_kind_ff   <= req_kind;
         s1_batch_ff  <= req_batch;
         s1_column_ff <= req_table_column;
         s1_block_ff  <= req_block_id;
         s1_index_ff  <= req_copy_index;
         s1_count_ff  <= req_copy_count;
         s1_token_ff  <= req_source_token;
         s1_slot_ff   <= req_destination_slot;
      end
   end

   // stage 1 checks and table addressing
   logic [15:0]    clamp_count;
   logic [SCW-1:0] src_col, dst_col;
   logic [31:0]    src_addr_full, dst_addr_full, wr_addr_full;
   logic           is_copy, is_write, write_in_range;
   logic           wr_src_en, wr_dst_en, rd_en;
   status_type     s2_status_in;

   assign src_col = s1_token_ff[30:OW];
   assign dst_col = s1_slot_ff[30:OW];
   assign src_addr_full = 32'(s1_batch_ff) * MAX_BLOCKS_U + 32'(src_col);
   assign dst_addr_full = 32'(s1_batch_ff) * MAX_BLOCKS_U + 32'(dst_col);
   assign wr_addr_full  = 32'(s1_batch_ff) * MAX_BLOCKS_U + 32'(s1_column_ff);
   assign is_copy  = (s1_kind_ff == KIND_COPY);
   assign is_write = (s1_kind_ff == KIND_WRITE_SOURCE) || (s1_kind_ff == KIND_WRITE_DEST);
   assign write_in_range = (32'(s1_batch_ff) < MAX_BATCHES_U) &&
                           (32'(s1_column_ff) < MAX_BLOCKS_U);
   assign wr_src_en = s1_move && write_in_range && (s1_kind_ff == KIND_WRITE_SOURCE);
   assign wr_dst_en = s1_move && write_in_range && (s1_kind_ff == KIND_WRITE_DEST);
   assign rd_en     = s1_move && is_copy;

   always_comb begin
      if (s1_count_ff[31]) begin
         clamp_count = 16'd0;
      end else if (s1_count_ff > 32'(capacity_ff)) begin
         clamp_count = capacity_ff;
      end else begin
         clamp_count = s1_count_ff[15:0];
      end
      priority if (s1_index_ff >= clamp_count) begin
         s2_status_in = ST_BEYOND_COUNT;
      end else if (s1_token_ff[31] || s1_slot_ff[31]) begin
         s2_status_in = ST_NEGATIVE;
      end else if ((32'(s1_batch_ff) >= MAX_BATCHES_U) ||
                   !(32'(src_col) < 32'(src_limit_ff)) || !(32'(src_col) < MAX_BLOCKS_U) ||
                   !(32'(dst_col) < 32'(dst_limit_ff)) || !(32'(dst_col) < MAX_BLOCKS_U)) begin
         s2_status_in = ST_COLUMN_RANGE;
      end else begin
         s2_status_in = ST_OK;
      end
   end

   logic [31:0] src_block, dst_block;

   prct_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_src_table (
      .clock   (clock),
      .wr_en   (wr_src_en),
      .wr_addr (wr_addr_full[AW-1:0]),
      .wr_data (s1_block_ff),
      .rd_en   (rd_en),
      .rd_addr (src_addr_full[AW-1:0]),
      .rd_data (src_block)
   );

   prct_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_dst_table (
      .clock   (clock),
      .wr_en   (wr_dst_en),
      .wr_addr (wr_addr_full[AW-1:0]),
      .wr_data (s1_block_ff),
      .rd_en   (rd_en),
      .rd_addr (dst_addr_full[AW-1:0]),
      .rd_data (dst_block)
   );

   // stage 2: table data arrives, build rows
   status_type    s2_status_ff;
   logic [OW-1:0] s2_src_off_ff, s2_dst_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_move && is_copy;
      end
      if (s2_ready) begin
         s2_status_ff  <= s2_status_in;
         s2_src_off_ff <= s1_token_ff[OW-1:0];
         s2_dst_off_ff <= s1_slot_ff[OW-1:0];
      end
   end

   status_type    s3_status_in, s3_status_ff;
   logic [RW-1:0] s3_src_row_in, s3_dst_row_in, s3_src_row_ff, s3_dst_row_ff;

   always_comb begin
      s3_status_in = s2_status_ff;
      if (s2_status_ff == ST_OK && (src_block[31] || dst_block[31])) begin
         s3_status_in = ST_UNMAPPED;
      end
      if (s3_status_in == ST_OK) begin
         s3_src_row_in = {src_block[30:0], s2_src_off_ff};
         s3_dst_row_in = {dst_block[30:0], s2_dst_off_ff};
      end else begin
         s3_src_row_in = '0;
         s3_dst_row_in = '0;
      end
   end

   // stage 3: rows registered, scale by row bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_ready) begin
         s3_status_ff  <= s3_status_in;
         s3_src_row_ff <= s3_src_row_in;
         s3_dst_row_ff <= s3_dst_row_in;
      end
   end

   logic [PW-1:0] src_prod_in, dst_prod_in;
   status_type    out_status_ff;
   logic [OFFSET_WIDTH-1:0] out_src_ff, out_dst_ff;

   assign src_prod_in = PW'(s3_src_row_ff) * PW'(row_bytes_ff);
   assign dst_prod_in = PW'(s3_dst_row_ff) * PW'(row_bytes_ff);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s3_valid_ff;
      end
      if (out_ready) begin
         out_status_ff <= s3_status_ff;
         out_src_ff    <= src_prod_in[OFFSET_WIDTH-1:0];
         out_dst_ff    <= dst_prod_in[OFFSET_WIDTH-1:0];
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_status                  = out_status_ff;
   assign rsp_source_byte_offset      = out_src_ff;
   assign rsp_destination_byte_offset = out_dst_ff;

   // checks
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_source_byte_offset == '0) && (rsp_destination_byte_offset == '0))
      else $error("skipped copy has nonzero offset");

   a_read_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_ready |-> !rd_en)
      else $error("table read while stage 2 is stalled");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      s1_move && !is_copy && !s2_valid_ff |=> !s2_valid_ff)
      else $error("table write entered the result path");

   a_write_exclusive: assert property (@(posedge clock) disable iff (reset)
      !((wr_src_en || wr_dst_en) && rd_en) && !(wr_src_en && wr_dst_en) &&
      !((wr_src_en || wr_dst_en) && !is_write))
      else $error("conflicting table accesses in one cycle");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s2_valid_ff && !s3_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
